### src/mbps_pkg.sv
// Package for the masked byte pattern scanner: beat types, register
// indexes and sizing constants. Depends on nothing; used by every module.
`timescale 1ns / 1ps

package mbps_pkg;

  localparam int unsigned MAX_PATTERN_BYTES_DEF = 32;
  localparam int unsigned PAT_WORDS             = 4;
  localparam int unsigned PAT_WORD_W            = 64;
  localparam int unsigned PAT_BYTES_FIX         = 32;
  localparam int unsigned LEN_W                 = 6;
  localparam int unsigned ADDR_W                = 32;
  localparam int unsigned CFG_IDX_W             = 4;
  localparam int unsigned CFG_DATA_W            = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_WORD0  = 4'd0,
    REG_PATTERN_WORD1  = 4'd1,
    REG_PATTERN_WORD2  = 4'd2,
    REG_PATTERN_WORD3  = 4'd3,
    REG_CARE_MASK      = 4'd4,
    REG_PATTERN_LENGTH = 4'd5,
    REG_RESULT_OFFSET  = 4'd6,
    REG_REGION_BASE    = 4'd7
  } mbps_reg_e;

  typedef struct packed {
    logic [7:0] region_byte;
    logic       last_byte;
  } mbps_in_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } mbps_out_t;

  // Control common to every cell of the window.
  typedef struct packed {
    logic shift;
    logic clear;
  } mbps_cell_ctrl_t;

  // Pattern byte lined up with one cell for the current length.
  typedef struct packed {
    logic [7:0] pat_byte;
    logic       care;
    logic       in_use;
  } mbps_cmp_t;

endpackage

### src/mbps_cell.sv
// One window cell of the pattern scanner: holds one byte, hands it to the
// next cell on each beat and compares the incoming byte. Uses mbps_pkg.
`timescale 1ns / 1ps

module mbps_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mbps_pkg::mbps_cell_ctrl_t ctrl_i,
  input  mbps_pkg::mbps_cmp_t     cmp_i,
  input  logic [7:0]              byte_i,
  output logic [7:0]              byte_o,
  output logic                    hit_o
);
  import mbps_pkg::*;

  logic [7:0] byte_q, byte_d;

  // The compare looks at the byte this cell takes on the current beat,
  // which is the window after the shift.
  assign hit_o = !cmp_i.in_use || !cmp_i.care || (byte_i == cmp_i.pat_byte);

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.shift) begin
      byte_d = ctrl_i.clear ? 8'd0 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'd0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

### src/masked_byte_pattern_scan.sv
// Top level of the masked byte pattern scanner: config registers, the row
// of window cells, region position tracking and the result register.
// Depends on mbps_pkg and mbps_cell.
//
//   channel   direction  handshake                 payload
//   cfg       in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//   in        in         in_valid_i / in_ready_o   in_data_i (mbps_in_t)
//   out       out        out_valid_o / out_ready_i out_data_o (mbps_out_t)
//
// One input beat per cycle when not stalled; a result beat is registered and
// shows the cycle after its byte; all cells compare in parallel on the beat.
// A held result stalls input only while out_ready_i is low; the next byte is
// taken in the same cycle the result leaves. Reset is asynchronous and
// needs no clearing pass; the config port is always ready.
`timescale 1ns / 1ps

module masked_byte_pattern_scan #(
  parameter int unsigned MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  mbps_pkg::mbps_in_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output mbps_pkg::mbps_out_t              out_data_o
);
  import mbps_pkg::*;

  // Config registers.
  logic [PAT_WORD_W-1:0] pat_word_q [PAT_WORDS];
  logic [PAT_BYTES_FIX-1:0] care_q;
  logic [LEN_W-1:0]      len_q;
  logic [ADDR_W-1:0]     offset_q;
  logic [ADDR_W-1:0]     base_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < PAT_WORDS; w++) begin
        pat_word_q[w] <= '0;
      end
      care_q   <= '0;
      len_q    <= LEN_W'(1);
      offset_q <= '0;
      base_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PATTERN_WORD0:  pat_word_q[0] <= cfg_data_i;
        REG_PATTERN_WORD1:  pat_word_q[1] <= cfg_data_i;
        REG_PATTERN_WORD2:  pat_word_q[2] <= cfg_data_i;
        REG_PATTERN_WORD3:  pat_word_q[3] <= cfg_data_i;
        REG_CARE_MASK:      care_q   <= cfg_data_i[PAT_BYTES_FIX-1:0];
        REG_PATTERN_LENGTH: len_q    <= cfg_data_i[LEN_W-1:0];
        REG_RESULT_OFFSET:  offset_q <= cfg_data_i[ADDR_W-1:0];
        REG_REGION_BASE:    base_q   <= cfg_data_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [PAT_BYTES_FIX*8-1:0] pat_flat;
  assign pat_flat = {pat_word_q[3], pat_word_q[2], pat_word_q[1], pat_word_q[0]};

  // Length in use, clamped to 1..MAX_PATTERN_BYTES.
  logic [LEN_W-1:0] act_len;
  always_comb begin
    if (len_q == '0) begin
      act_len = LEN_W'(1);
    end else if (len_q > LEN_W'(MAX_PATTERN_BYTES)) begin
      act_len = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      act_len = len_q;
    end
  end

  // Region state and handshake.
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic              reported_q, reported_d;
  logic              out_valid_q, out_valid_d;
  mbps_out_t         out_data_q, out_data_d;
  logic              acc, full_hit, match, emit;
  mbps_cell_ctrl_t   cell_ctrl;

  assign in_ready_o      = !out_valid_q || out_ready_i;
  assign acc             = in_valid_i && in_ready_o;
  assign cell_ctrl.shift = acc;
  assign cell_ctrl.clear = in_data_i.last_byte;

  // Row of cells; cell i holds the byte received i beats ago and lines up
  // with pattern byte act_len-1-i.
  logic [7:0]                   chain [MAX_PATTERN_BYTES+1];
  logic [MAX_PATTERN_BYTES-1:0] hits;

  assign chain[0] = in_data_i.region_byte;

  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
    logic [LEN_W-1:0] k;
    mbps_cmp_t        cmp;
    assign k = act_len - LEN_W'(1) - LEN_W'(i);
    assign cmp.in_use   = LEN_W'(i) < act_len;
    assign cmp.pat_byte = pat_flat[k[4:0]*8 +: 8];
    assign cmp.care     = care_q[k[4:0]];

    mbps_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .cmp_i  (cmp),
      .byte_i (chain[i]),
      .byte_o (chain[i+1]),
      .hit_o  (hits[i])
    );
  end

  // The last cell's byte only leaves the window.
  logic [7:0] spill;
  assign spill = chain[MAX_PATTERN_BYTES];

  logic [ADDR_W-1:0] len_m1;
  assign len_m1   = ADDR_W'(act_len - LEN_W'(1));
  assign full_hit = &hits;
  assign match    = !reported_q && (pos_q >= len_m1) && full_hit;
  assign emit     = match || (in_data_i.last_byte && !reported_q);

  always_comb begin
    pos_d       = pos_q;
    reported_d  = reported_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (acc) begin
      if (in_data_i.last_byte) begin
        pos_d      = '0;
        reported_d = 1'b0;
      end else begin
        // Saturating count keeps a very long region from wrapping.
        if (pos_q != '1) begin
          pos_d = pos_q + ADDR_W'(1);
        end
        reported_d = reported_q || match;
      end
      if (emit) begin
        out_valid_d = 1'b1;
        out_data_d.found = match;
        out_data_d.match_address = match ? (base_q + (pos_q - len_m1) + offset_q)
                                         : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      reported_q  <= reported_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |-> (out_data_o.match_address == '0))
    else $error("not-found result carries a nonzero address");

  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_data_i.last_byte) |=> (pos_q == '0 && !reported_q))
    else $error("region state not cleared after last byte");

  a_match_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && match && !in_data_i.last_byte) |=> reported_q)
    else $error("match not recorded for the region");

  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && reported_q && !in_data_i.last_byte) |=> !out_valid_o)
    else $error("second result in one region");

  a_spill_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_data_i.last_byte) |=> (spill == 8'd0))
    else $error("window not cleared after last byte");
`endif

endmodule

### sim/tb_masked_byte_pattern_scan.sv
// Testbench for masked_byte_pattern_scan: a directed table and random regions with
// planted patterns, each result beat checked against a table row or window predictor.
// Depends on mbps_pkg and the scanner RTL.
`timescale 1ns / 1ps

module tb_masked_byte_pattern_scan;
  import mbps_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned DRAIN_CYCLES = 4;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_e;
  typedef enum logic [1:0] {EXP_MODEL, EXP_FOUND, EXP_MISS} row_exp_e;

  typedef struct {
    row_kind_e   kind;
    mbps_reg_e   reg_idx;
    logic [63:0] value;
    logic [7:0]  data;
    logic        last;
    row_exp_e    exp;
    logic [31:0] addr;
  } dir_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  mbps_in_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  mbps_out_t             out_data_o;

  masked_byte_pattern_scan u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Shadow registers and window state of the predictor.
  logic [63:0] pat_w [4];
  logic [31:0] care_q;
  logic [5:0]  len_q;
  logic [31:0] offset_q;
  logic [31:0] base_q;
  logic [7:0]  win_q [32];
  logic [31:0] pos_q;
  bit          reported_q;

  mbps_out_t   match_reports_q[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  bit          calm = 1'b0;
  dir_row_t    dir_rows[$];

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned eff_len();
    if (len_q == 6'd0) return 1;
    if (len_q > 6'd32) return 32;
    return int'(len_q);
  endfunction

  function automatic logic [7:0] pat_byte(input int unsigned k);
    return pat_w[k / 8][(k % 8) * 8 +: 8];
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < 32; i++) win_q[i] = 8'h00;
    pos_q      = '0;
    reported_q = 1'b0;
  endfunction

  // Shifts one byte into the window and returns 1 when that byte causes a result.
  function automatic bit scan_advance(input logic [7:0] b, input logic last,
                                      output mbps_out_t res);
    int unsigned len;
    logic [31:0] idx;
    bit          hit;
    bit          ok;
    len = eff_len();
    idx = pos_q;
    hit = 1'b0;
    res = '0;
    for (int i = 31; i > 0; i--) win_q[i] = win_q[i-1];
    win_q[0] = b;
    if (pos_q != 32'hFFFF_FFFF) pos_q++;
    if (!reported_q && idx >= 32'(len - 1)) begin
      ok = 1'b1;
      for (int unsigned k = 0; k < len; k++) begin
        if (care_q[k] && win_q[len - 1 - k] != pat_byte(k)) ok = 1'b0;
      end
      if (ok) begin
        res.found         = 1'b1;
        res.match_address = base_q + (idx - 32'(len - 1)) + offset_q;
        reported_q        = 1'b1;
        hit               = 1'b1;
      end
    end
    if (!hit && last && !reported_q) hit = 1'b1;
    if (last) clear_window();
    return hit;
  endfunction

  function automatic dir_row_t cfg_row(input mbps_reg_e idx, input logic [63:0] value);
    dir_row_t r;
    r = '{kind: ROW_CFG, reg_idx: idx, value: value, data: 8'h00, last: 1'b0,
          exp: EXP_MODEL, addr: 32'h0};
    return r;
  endfunction

  function automatic dir_row_t byte_row(input logic [7:0] data, input logic last,
                                        input row_exp_e exp, input logic [31:0] addr);
    dir_row_t r;
    r = '{kind: ROW_BYTE, reg_idx: REG_PATTERN_WORD0, value: 64'h0, data: data,
          last: last, exp: exp, addr: addr};
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // Holds the config beat valid until taken; the caller lowers valid after a batch.
  task automatic write_reg(input mbps_reg_e idx, input logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_PATTERN_WORD0:  pat_w[0] = value;
      REG_PATTERN_WORD1:  pat_w[1] = value;
      REG_PATTERN_WORD2:  pat_w[2] = value;
      REG_PATTERN_WORD3:  pat_w[3] = value;
      REG_CARE_MASK:      care_q   = value[31:0];
      REG_PATTERN_LENGTH: len_q    = value[5:0];
      REG_RESULT_OFFSET:  offset_q = value[31:0];
      REG_REGION_BASE:    base_q   = value[31:0];
      default: ;
    endcase
  endtask

  // Waits until every result has left, then lets the pipeline settle, since a
  // byte with no result may still be in flight.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (match_reports_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input row_exp_e exp,
                           input logic [31:0] addr);
    int unsigned gap;
    mbps_in_t    beat;
    mbps_out_t   res;
    bit          hit;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    beat.region_byte = b;
    beat.last_byte   = last;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    hit = scan_advance(b, last, res);
    case (exp)
      EXP_FOUND: begin
        res.found         = 1'b1;
        res.match_address = addr;
        match_reports_q.push_back(res);
      end
      EXP_MISS:  match_reports_q.push_back('0);
      default:   if (hit) match_reports_q.push_back(res);
    endcase
  endtask

  initial begin : result_sink
    int unsigned stall;
    mbps_out_t   want;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (match_reports_q.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing expected: found=%0b addr=%08h",
                                out_data_o.found, out_data_o.match_address));
      end else begin
        want = match_reports_q.pop_front();
        if (out_data_o.found !== want.found)
          flag_mismatch($sformatf("found %0b, expected %0b",
                                  out_data_o.found, want.found));
        if (out_data_o.match_address !== want.match_address)
          flag_mismatch($sformatf("match_address %08h, expected %08h",
                                  out_data_o.match_address, want.match_address));
      end
    end
  end

  initial begin : stimulus
    logic [63:0] vals [8];
    logic [7:0]  region_bytes [64];
    int unsigned len;
    int unsigned size;
    int unsigned start;
    int unsigned k;
    int unsigned pick;
    int unsigned phase_goal;
    int unsigned phase_items;
    bit          near_miss;

    for (int i = 0; i < 4; i++) pat_w[i] = '0;
    care_q   = '0;
    len_q    = 6'd1;
    offset_q = '0;
    base_q   = '0;
    clear_window();

    // After reset: length one with an empty mask, so every byte matches.
    dir_rows.push_back(byte_row(8'h00, 1'b0, EXP_FOUND, 32'h0));
    dir_rows.push_back(byte_row(8'hFF, 1'b0, EXP_MODEL, 32'h0));
    dir_rows.push_back(byte_row(8'h5A, 1'b1, EXP_MODEL, 32'h0));
    dir_rows.push_back(byte_row(8'h80, 1'b1, EXP_FOUND, 32'h0));
    // Length zero acts as one; address arithmetic wraps.
    dir_rows.push_back(cfg_row(REG_PATTERN_WORD0, 64'h0000_0000_0000_00A5));
    dir_rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd0));
    dir_rows.push_back(cfg_row(REG_CARE_MASK, 64'h1));
    dir_rows.push_back(cfg_row(REG_REGION_BASE, 64'hFFFF_FFFF));
    dir_rows.push_back(cfg_row(REG_RESULT_OFFSET, 64'hFFFF_FFFF));
    dir_rows.push_back(byte_row(8'h00, 1'b0, EXP_MODEL, 32'h0));
    dir_rows.push_back(byte_row(8'hA5, 1'b0, EXP_FOUND, 32'hFFFF_FFFF));
    dir_rows.push_back(byte_row(8'hA5, 1'b1, EXP_MODEL, 32'h0));
    dir_rows.push_back(byte_row(8'h3C, 1'b1, EXP_MISS, 32'h0));
    // Four bytes with a wildcard in the third; care bits above the length are ignored.
    dir_rows.push_back(cfg_row(REG_PATTERN_WORD0, 64'hFFFF_FFFF_1122_3344));
    dir_rows.push_back(cfg_row(REG_PATTERN_WORD1, 64'hFFFF_FFFF_FFFF_FFFF));
    dir_rows.push_back(cfg_row(REG_PATTERN_WORD2, 64'h0));
    dir_rows.push_back(cfg_row(REG_PATTERN_WORD3, 64'h8000_0000_0000_0001));
    dir_rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd4));
    dir_rows.push_back(cfg_row(REG_CARE_MASK, 64'hFFFF_FFFB));
    dir_rows.push_back(cfg_row(REG_REGION_BASE, 64'h1000));
    dir_rows.push_back(cfg_row(REG_RESULT_OFFSET, 64'h10));
    dir_rows.push_back(byte_row(8'h44, 1'b0, EXP_MODEL, 32'h0));
    dir_rows.push_back(byte_row(8'h33, 1'b1, EXP_MISS, 32'h0));
    // The bytes of the previous region must not complete a match here.
    dir_rows.push_back(byte_row(8'h11, 1'b0, EXP_MODEL, 32'h0));
    dir_rows.push_back(byte_row(8'h44, 1'b0, EXP_MODEL, 32'h0));
    dir_rows.push_back(byte_row(8'h33, 1'b0, EXP_MODEL, 32'h0));
    dir_rows.push_back(byte_row(8'h99, 1'b0, EXP_MODEL, 32'h0));
    dir_rows.push_back(byte_row(8'h11, 1'b0, EXP_MODEL, 32'h0));
    dir_rows.push_back(byte_row(8'h44, 1'b1, EXP_MODEL, 32'h0));
    // Length above the maximum acts as 32, so a short region never fills the window.
    dir_rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd63));
    dir_rows.push_back(cfg_row(REG_CARE_MASK, 64'h0));
    dir_rows.push_back(byte_row(8'h00, 1'b0, EXP_MODEL, 32'h0));
    dir_rows.push_back(byte_row(8'hFF, 1'b0, EXP_MODEL, 32'h0));
    dir_rows.push_back(byte_row(8'h7E, 1'b1, EXP_MISS, 32'h0));
    dir_rows.push_back(cfg_row(REG_PATTERN_WORD0, 64'h0000_0000_0000_FF00));
    dir_rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd2));
    dir_rows.push_back(cfg_row(REG_CARE_MASK, 64'h3));
    dir_rows.push_back(byte_row(8'h00, 1'b0, EXP_MODEL, 32'h0));
    dir_rows.push_back(byte_row(8'hFF, 1'b1, EXP_MODEL, 32'h0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (i == 0 || dir_rows[i-1].kind != ROW_CFG) wait_idle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
        if (i + 1 == dir_rows.size() || dir_rows[i+1].kind != ROW_CFG)
          cfg_valid_i <= 1'b0;
      end else begin
        send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].exp, dir_rows[i].addr);
      end
    end

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      wait_idle();
      pick = $urandom_range(0, 19);
      if (pick < 5)       vals[REG_PATTERN_LENGTH] = 64'd1;
      else if (pick < 8)  vals[REG_PATTERN_LENGTH] = 64'd32;
      else if (pick == 8) vals[REG_PATTERN_LENGTH] = 64'd0;
      else if (pick == 9) vals[REG_PATTERN_LENGTH] = 64'($urandom_range(33, 63));
      else                vals[REG_PATTERN_LENGTH] = 64'($urandom_range(2, 12));
      for (int w = 0; w < 4; w++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)      vals[w] = '0;
        else if (pick == 1) vals[w] = '1;
        else                vals[w] = {$urandom, $urandom};
      end
      pick = $urandom_range(0, 9);
      vals[REG_CARE_MASK] = (pick == 0) ? 64'h0 :
                            (pick == 1) ? 64'hFFFF_FFFF : 64'($urandom);
      pick = $urandom_range(0, 5);
      vals[REG_RESULT_OFFSET] = (pick == 0) ? 64'hFFFF_FFFF :
                                (pick == 1) ? 64'h0 : 64'($urandom);
      pick = $urandom_range(0, 5);
      vals[REG_REGION_BASE] = (pick == 0) ? 64'hFFFF_FFFF :
                              (pick == 1) ? 64'h0 : 64'($urandom);
      for (int r = 0; r < 8; r++) write_reg(mbps_reg_e'(r), vals[r]);
      cfg_valid_i <= 1'b0;

      calm        = ($urandom_range(0, 3) == 0);
      len         = eff_len();
      phase_goal  = $urandom_range(40, 120);
      phase_items = 0;
      while (phase_items < phase_goal && items_sent < RANDOM_ITEMS) begin
        if ($urandom_range(0, 11) == 0) wait_idle();
        size = (len >= 20) ? $urandom_range(len - 2, len + 8) : $urandom_range(1, len + 12);
        // Near-miss filler uses pattern bytes so that partial matches are common.
        near_miss = $urandom_range(0, 1);
        for (int i = 0; i < size; i++)
          region_bytes[i] = near_miss ? pat_byte($urandom_range(0, len - 1))
                                      : 8'($urandom);
        if (size >= len && $urandom_range(0, 99) < 70) begin
          start = $urandom_range(0, size - len);
          for (int unsigned j = 0; j < len; j++)
            if (care_q[j]) region_bytes[start + j] = pat_byte(j);
          if ($urandom_range(0, 4) == 0) begin
            k = $urandom_range(0, len - 1);
            region_bytes[start + k] ^= 8'(1 << $urandom_range(0, 7));
          end
          if ($urandom_range(0, 3) == 0) begin
            start = $urandom_range(0, size - len);
            for (int unsigned j = 0; j < len; j++)
              if (care_q[j]) region_bytes[start + j] = pat_byte(j);
          end
        end
        for (int i = 0; i < size; i++)
          send_byte(region_bytes[i], (i == size - 1), EXP_MODEL, 32'h0);
        phase_items += size;
      end
    end

    in_valid_i <= 1'b0;
    while (match_reports_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
